/* design/blhm_pkg.sv */
// shared constants for the battery level hysteresis monitor
package blhm_pkg;

    // data widths
    localparam int ADC_W  = 12;
    localparam int HYS_W  = 10;
    localparam int LVL_W  = 3;
    localparam int CMP_W  = 14;   // signed compare width, holds thr +/- hysteresis
    localparam int SIN_W  = 16;   // s_tdata width
    localparam int MOUT_W = 32;   // m_tdata width

    // filter and confirm settings
    localparam int FILTER_SHIFT  = 3;
    localparam int CONFIRM_COUNT = 3;
    localparam int CNT_W         = $clog2(CONFIRM_COUNT + 1);

    localparam logic [ADC_W-1:0] ADC_MAX = {ADC_W{1'b1}};

    // level codes
    localparam logic [LVL_W-1:0] LV_FULL = 3'd0;
    localparam logic [LVL_W-1:0] LV_HIGH = 3'd1;
    localparam logic [LVL_W-1:0] LV_MID  = 3'd2;
    localparam logic [LVL_W-1:0] LV_LOW  = 3'd3;
    localparam logic [LVL_W-1:0] LV_CRIT = 3'd4;

    // request kinds carried in s_tuser
    localparam logic REQ_STEP = 1'b0;
    localparam logic REQ_INIT = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VLOW_THR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HYST      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_H    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_V1   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_V2   = 3'd7;

    // configuration reset values
    localparam logic [ADC_W-1:0] RST_FULL_THR = 12'd3200;
    localparam logic [ADC_W-1:0] RST_MID_THR  = 12'd2900;
    localparam logic [ADC_W-1:0] RST_LOW_THR  = 12'd2600;
    localparam logic [ADC_W-1:0] RST_VLOW_THR = 12'd2400;
    localparam logic [HYS_W-1:0] RST_HYST     = 10'd20;
    localparam logic [HYS_W-1:0] RST_DROP     = 10'd40;

endpackage

/* design/battery_level_hysteresis_monitor_core.sv */
// battery level hysteresis monitor: filter, drop compensation, level tracking
//
// channel   dir  width  beat content
// -------   ---  -----  -----------------------------------------------------
// s_ (in)   in   16+1   tdata: adc sample, laser flags; tuser: request kind
// m_ (out)  out  32     tdata: level, shutdown, filtered, compensated, blink
// cfg_      in   3+12   write enable, register index, write data
//
// one beat in, one beat out; a new sample can enter every cycle while m_tready is high
// a beat passes the input register, then the result register
// filter, compensation and level state update together as the beat leaves the input register
// aresetn is synchronous, clears filter, level, counter and config to defaults
// a stalled result register holds its beat while the input register still
// takes one more sample, so s_tready only drops when both stages are full
module battery_level_hysteresis_monitor_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [11:0] adc_sample, [12] laser_h_on, [13] laser_v1_on, [14] laser_v2_on
    input  logic [blhm_pkg::SIN_W-1:0]  s_tdata,
    // [0] req_type
    input  logic                        s_tuser,
    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [2:0] level_state, [3] shutdown_request, [15:4] filtered_value,
    // [27:16] compensated_value, [28] low_blink
    output logic [blhm_pkg::MOUT_W-1:0] m_tdata,
    // configuration write port
    input  logic                        cfg_wr_en,
    input  logic [blhm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [blhm_pkg::ADC_W-1:0]  cfg_wdata
);
    import blhm_pkg::*;

    // configuration registers
    logic [ADC_W-1:0] full_thr_reg, mid_thr_reg, low_thr_reg, vlow_thr_reg;
    logic [HYS_W-1:0] hyst_reg, drop_h_reg, drop_v1_reg, drop_v2_reg;

    // input stage
    logic             in_valid_reg;
    logic             in_req_reg;
    logic [ADC_W-1:0] in_sample_reg;
    logic             in_lh_reg, in_lv1_reg, in_lv2_reg;

    // block state
    logic [ADC_W-1:0] filt_reg, filt_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic [CNT_W-1:0] crit_cnt_reg, crit_cnt_next;
    logic             shutdown_reg, shutdown_next;

    // result stage
    logic             out_valid_reg;
    logic [ADC_W-1:0] out_comp_reg, comp_next;

    logic s_fire;
    logic advance;
    logic do_item;

    // filter datapath
    logic signed [ADC_W:0]   delta;
    logic signed [ADC_W:0]   delta_sh;
    logic signed [CMP_W-1:0] filt_sum;
    logic [ADC_W-1:0]        filt_clamp;
    logic [ADC_W-1:0]        filt_step;
    logic [ADC_W:0]          comp_sum;
    logic [ADC_W-1:0]        comp_sat;

    // signed compare operands
    logic signed [CMP_W-1:0] v_s, full_s, mid_s, low_s, vlow_s, hys_s;
    logic [LVL_W-1:0]        step_level;
    logic [LVL_W-1:0]        init_level;

    // handshake: result register frees up when empty or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign do_item  = in_valid_reg && advance;

    // first-order filter, arithmetic shift rounds toward minus infinity
    always_comb begin
        delta    = $signed({1'b0, in_sample_reg}) - $signed({1'b0, filt_reg});
        delta_sh = delta >>> FILTER_SHIFT;
        filt_sum = $signed({2'b00, filt_reg})
                   + $signed({{(CMP_W-ADC_W-1){delta_sh[ADC_W]}}, delta_sh});
        if (filt_sum < 0) begin
            filt_clamp = '0;
        end else if (filt_sum > $signed({2'b00, ADC_MAX})) begin
            filt_clamp = ADC_MAX;
        end else begin
            filt_clamp = filt_sum[ADC_W-1:0];
        end
        // zero accumulator means not loaded yet: take the raw sample
        filt_step = (filt_reg == '0) ? in_sample_reg : filt_clamp;
    end

    // ir-drop compensation per active laser, saturated at full scale
    always_comb begin
        comp_sum = {1'b0, filt_step}
                   + (in_lh_reg  ? {3'b000, drop_h_reg}  : '0)
                   + (in_lv1_reg ? {3'b000, drop_v1_reg} : '0)
                   + (in_lv2_reg ? {3'b000, drop_v2_reg} : '0);
        comp_sat = comp_sum[ADC_W] ? ADC_MAX : comp_sum[ADC_W-1:0];
    end

    // hysteresis level tracking, signed so thr - hys may go negative
    always_comb begin
        v_s    = $signed({2'b00, comp_sat});
        full_s = $signed({2'b00, full_thr_reg});
        mid_s  = $signed({2'b00, mid_thr_reg});
        low_s  = $signed({2'b00, low_thr_reg});
        vlow_s = $signed({2'b00, vlow_thr_reg});
        hys_s  = $signed({4'b0000, hyst_reg});
        unique case (level_reg)
            LV_FULL: begin
                step_level = (v_s < full_s - hys_s) ? LV_HIGH : LV_FULL;
            end
            LV_HIGH: begin
                if (v_s >= full_s + hys_s) begin
                    step_level = LV_FULL;
                end else if (v_s < mid_s - hys_s) begin
                    step_level = LV_MID;
                end else begin
                    step_level = LV_HIGH;
                end
            end
            LV_MID: begin
                if (v_s >= mid_s + hys_s) begin
                    step_level = LV_HIGH;
                end else if (v_s < low_s - hys_s) begin
                    step_level = LV_LOW;
                end else begin
                    step_level = LV_MID;
                end
            end
            LV_LOW: begin
                if (v_s >= low_s + hys_s) begin
                    step_level = LV_MID;
                end else if (v_s < vlow_s) begin
                    step_level = LV_CRIT;
                end else begin
                    step_level = LV_LOW;
                end
            end
            LV_CRIT: begin
                // back to low at the plain low threshold, no hysteresis
                step_level = (v_s >= low_s) ? LV_LOW : LV_CRIT;
            end
            default: begin
                step_level = LV_CRIT;
            end
        endcase
    end

    // direct classification on an init request
    always_comb begin
        priority if (in_sample_reg >= full_thr_reg) begin
            init_level = LV_FULL;
        end else if (in_sample_reg >= mid_thr_reg) begin
            init_level = LV_HIGH;
        end else if (in_sample_reg >= low_thr_reg) begin
            init_level = LV_MID;
        end else if (in_sample_reg >= vlow_thr_reg) begin
            init_level = LV_LOW;
        end else begin
            init_level = LV_CRIT;
        end
    end

    // next state for the item in the input register
    always_comb begin
        filt_next     = filt_reg;
        level_next    = level_reg;
        crit_cnt_next = crit_cnt_reg;
        shutdown_next = shutdown_reg;
        comp_next     = out_comp_reg;
        if (do_item) begin
            if (in_req_reg == REQ_INIT) begin
                filt_next     = in_sample_reg;
                level_next    = init_level;
                // count follows the very-low compare alone, even with unordered thresholds
                crit_cnt_next = (in_sample_reg < vlow_thr_reg) ? CNT_W'(1) : '0;
                shutdown_next = 1'b0;
                comp_next     = in_sample_reg;
            end else begin
                filt_next  = filt_step;
                level_next = step_level;
                comp_next  = comp_sat;
                if (step_level == LV_CRIT) begin
                    if (crit_cnt_reg < CNT_W'(CONFIRM_COUNT)) begin
                        crit_cnt_next = crit_cnt_reg + CNT_W'(1);
                    end
                end else begin
                    crit_cnt_next = '0;
                    shutdown_next = 1'b0;
                end
                // confirmed critical raises the shutdown request
                if (crit_cnt_next >= CNT_W'(CONFIRM_COUNT)) begin
                    shutdown_next = 1'b1;
                end
            end
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_thr_reg <= RST_FULL_THR;
            mid_thr_reg  <= RST_MID_THR;
            low_thr_reg  <= RST_LOW_THR;
            vlow_thr_reg <= RST_VLOW_THR;
            hyst_reg     <= RST_HYST;
            drop_h_reg   <= RST_DROP;
            drop_v1_reg  <= RST_DROP;
            drop_v2_reg  <= RST_DROP;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FULL_THR: full_thr_reg <= cfg_wdata;
                CFG_MID_THR:  mid_thr_reg  <= cfg_wdata;
                CFG_LOW_THR:  low_thr_reg  <= cfg_wdata;
                CFG_VLOW_THR: vlow_thr_reg <= cfg_wdata;
                CFG_HYST:     hyst_reg     <= cfg_wdata[HYS_W-1:0];
                CFG_DROP_H:   drop_h_reg   <= cfg_wdata[HYS_W-1:0];
                CFG_DROP_V1:  drop_v1_reg  <= cfg_wdata[HYS_W-1:0];
                CFG_DROP_V2:  drop_v2_reg  <= cfg_wdata[HYS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            filt_reg      <= '0;
            level_reg     <= LV_FULL;
            crit_cnt_reg  <= '0;
            shutdown_reg  <= 1'b0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            filt_reg     <= filt_next;
            level_reg    <= level_next;
            crit_cnt_reg <= crit_cnt_next;
            shutdown_reg <= shutdown_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_req_reg    <= s_tuser;
            in_sample_reg <= s_tdata[ADC_W-1:0];
            in_lh_reg     <= s_tdata[ADC_W];
            in_lv1_reg    <= s_tdata[ADC_W+1];
            in_lv2_reg    <= s_tdata[ADC_W+2];
        end
        out_comp_reg <= comp_next;
    end

    // result beat straight from the state registers
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, (level_reg == LV_LOW), out_comp_reg, filt_reg,
                       shutdown_reg, level_reg};

    // checks
    a_shutdown_only_critical: assert property (@(posedge aclk) disable iff (!aresetn)
        shutdown_reg |-> (level_reg == LV_CRIT))
        else $error("shutdown request outside critical level");

    a_count_outside_critical: assert property (@(posedge aclk) disable iff (!aresetn)
        ((crit_cnt_reg != '0) && (level_reg != LV_CRIT)) |-> (crit_cnt_reg == CNT_W'(1)))
        else $error("critical count running outside critical level");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        crit_cnt_reg <= CNT_W'(CONFIRM_COUNT))
        else $error("critical count beyond confirm limit");

    a_shutdown_confirmed: assert property (@(posedge aclk) disable iff (!aresetn)
        shutdown_reg |-> (crit_cnt_reg >= CNT_W'(CONFIRM_COUNT)))
        else $error("shutdown request without confirmed critical count");

    a_held_result_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> ($stable(level_reg) && $stable(filt_reg)))
        else $error("state moved while result beat was stalled");

endmodule
